@@ src/orq_pkg.sv @@
// ----------------------------------------------------------------------------
// orq_pkg
// Shared command, status and control types for the ordered ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package orq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_EMPTY = 2'd3
  } stat_e_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_step;
    logic    push_write;
    logic    bub_read;
    logic    bub_move;
    logic    place;
    logic    fetch;
    logic    take;
    logic    clear;
    logic    set_res;
    stat_e_t res_status;
    logic    out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e_t cmd;
    logic   full;
    logic   empty;
    logic   match;
    logic   last;
    logic   bub_stop;
    logic   prev_ge;
    logic   out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ src/orq_ctrl.sv @@
// ----------------------------------------------------------------------------
// orq_ctrl
// Command sequencer: duplicate scan, push, bubbling, pop/peek, clear and result
// hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module orq_ctrl
  import orq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic unique_en,
  input  wire logic sorted_en,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      idle
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_SCAN    = 9'b000000100,
    S_WRITE   = 9'b000001000,
    S_BUB_RD  = 9'b000010000,
    S_BUB_CMP = 9'b000100000,
    S_READ    = 9'b001000000,
    S_DONE    = 9'b010000000,
    S_HOLD    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (sts.cmd)
          CMD_PUSH: begin
            if (sts.full) begin
              ctl.set_res    = 1'b1;
              ctl.res_status = ST_FULL;
              state_next     = S_DONE;
            end else if (unique_en && !sts.empty) begin
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end else begin
              state_next = S_WRITE;
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (sts.empty) begin
              ctl.set_res    = 1'b1;
              ctl.res_status = ST_EMPTY;
              state_next     = S_DONE;
            end else begin
              ctl.fetch  = 1'b1;
              state_next = S_READ;
            end
          end
          CMD_CLEAR: begin
            ctl.clear      = 1'b1;
            ctl.set_res    = 1'b1;
            ctl.res_status = ST_OK;
            state_next     = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          ctl.set_res    = 1'b1;
          ctl.res_status = ST_DUP;
          state_next     = S_DONE;
        end else if (sts.last) begin
          state_next = S_WRITE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_WRITE: begin
        ctl.push_write = 1'b1;
        if (sorted_en) begin
          state_next = S_BUB_RD;
        end else begin
          ctl.set_res    = 1'b1;
          ctl.res_status = ST_OK;
          state_next     = S_DONE;
        end
      end
      S_BUB_RD: begin
        if (sts.bub_stop) begin
          ctl.place      = 1'b1;
          ctl.set_res    = 1'b1;
          ctl.res_status = ST_OK;
          state_next     = S_DONE;
        end else begin
          ctl.bub_read = 1'b1;
          state_next   = S_BUB_CMP;
        end
      end
      S_BUB_CMP: begin
        if (sts.prev_ge) begin
          ctl.place      = 1'b1;
          ctl.set_res    = 1'b1;
          ctl.res_status = ST_OK;
          state_next     = S_DONE;
        end else begin
          ctl.bub_move = 1'b1;
          state_next   = S_BUB_RD;
        end
      end
      S_READ: begin
        ctl.take       = 1'b1;
        ctl.set_res    = 1'b1;
        ctl.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_DONE: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/orq_dp.sv @@
// ----------------------------------------------------------------------------
// orq_dp
// Queue datapath: slot memory, head/tail/count, scan and bubble pointer,
// result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module orq_dp
  import orq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_t        ctl,
  output sts_t             sts,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] push_value,
  input  wire logic [4:0]  cap,
  input  wire logic        invert_en,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      out_value,
  output logic [4:0]       entry_count,
  output logic             is_empty,
  output logic             is_full
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] res_value;
  cmd_e_t               cmd_r;
  stat_e_t              res_status;
  logic [IW-1:0]        head;
  logic [IW-1:0]        tail;
  logic [IW-1:0]        ptr;
  logic [CW-1:0]        count;
  logic [CW-1:0]        left;

  logic [CW-1:0]        eff;
  logic [EW-1:0]        cap_w;
  logic [IW-1:0]        up_ptr;
  logic [IW-1:0]        down_ptr;
  logic [IW-1:0]        fetch_addr;
  logic [IW-1:0]        rd_addr;
  logic                 we;
  logic [IW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;
  logic                 full;

  function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i, input logic [CW-1:0] e);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= e) ? '0 : IW'(n);
  endfunction

  function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i, input logic [CW-1:0] e);
    logic [CW-1:0] m;
    m = e - CW'(1);
    return (i == '0) ? IW'(m) : i - IW'(1);
  endfunction

  // capacity of zero or beyond the slot count means the full depth
  assign cap_w = EW'(cap);
  assign eff   = (cap == 5'd0 || cap_w > EW'(DEPTH)) ? CW'(DEPTH) : CW'(cap);

  assign up_ptr     = step_up(ptr, eff);
  assign down_ptr   = step_down(ptr, eff);
  assign fetch_addr = invert_en ? step_down(tail, eff) : head;
  assign full       = (count >= eff);

  always_comb begin
    rd_addr = ptr;
    if (ctl.scan_start) begin
      rd_addr = head;
    end else if (ctl.scan_step) begin
      rd_addr = up_ptr;
    end else if (ctl.bub_read) begin
      rd_addr = down_ptr;
    end else if (ctl.fetch) begin
      rd_addr = fetch_addr;
    end
  end

  always_comb begin
    we = ctl.push_write | ctl.bub_move | ctl.place;
    wa = ptr;
    wd = word_r;
    if (ctl.push_write) begin
      wa = tail;
    end else if (ctl.bub_move) begin
      wd = rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r <= WORD_BITS'(push_value);
    end
    if (ctl.scan_start) begin
      ptr  <= head;
      left <= count;
    end else if (ctl.scan_step) begin
      ptr  <= up_ptr;
      left <= left - CW'(1);
    end else if (ctl.push_write) begin
      ptr  <= tail;
      left <= count;
    end else if (ctl.bub_move) begin
      ptr  <= down_ptr;
      left <= left - CW'(1);
    end else if (ctl.fetch) begin
      ptr <= fetch_addr;
    end
    if (ctl.set_res) begin
      res_status <= ctl.res_status;
      res_value  <= ctl.take ? rd_q : '0;
    end
    if (ctl.out_load) begin
      status      <= res_status;
      out_value   <= 32'(res_value);
      entry_count <= 5'(count);
      is_empty    <= (count == '0);
      is_full     <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_r     <= CMD_PUSH;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        cmd_r <= cmd_e_t'(cmd);
      end
      if (ctl.clear) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (ctl.push_write) begin
        tail  <= step_up(tail, eff);
        count <= count + CW'(1);
      end else if (ctl.take && cmd_r == CMD_POP) begin
        if (invert_en) begin
          tail <= ptr;
        end else begin
          head <= step_up(head, eff);
        end
        count <= count - CW'(1);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts          = '0;
    sts.cmd      = cmd_r;
    sts.full     = full;
    sts.empty    = (count == '0);
    sts.match    = (rd_q == word_r);
    sts.last     = (left == CW'(1));
    sts.bub_stop = (left == '0) || (ptr == head);
    sts.prev_ge  = (rd_q >= word_r);
    sts.out_free = !out_valid || !out_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_write_one_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.push_write, ctl.bub_move, ctl.place}))
    else $error("conflicting slot writes");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    ctl.push_write |=> count == $past(count) + CW'(1))
    else $error("push did not add one entry");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> count != '0)
    else $error("read from empty queue");

endmodule

`default_nettype wire

@@ src/ordered_ring_queue_core.sv @@
// ----------------------------------------------------------------------------
// ordered_ring_queue_core
// Ring-buffer queue with push, pop, peek and clear; optional duplicate
// rejection, sorted insertion (largest at head) and tail-side reads.
//
// Input channel (in_valid/in_stall) carries cmd and push_value; output
// channel (out_valid/out_stall) returns status, out_value, entry_count,
// is_empty and is_full, one result per command, in order.
// One command is processed at a time. From the transfer to the result
// being loaded in the output register, every command passes the check
// state; a push then runs the duplicate scan in unique mode, the slot
// write, and in sorted mode the bubbling swaps until it stops and places
// the word; a pop or peek reads its slot before the result is set.
// The next command is taken once the result sits in the output register,
// so one result can wait under out_stall while the next command runs;
// a second finished result holds the sequencer until the first is taken.
// Reset empties the queue, clears head and tail, and sets capacity to 16
// with all modes off; slot contents are not cleared.
// Registers over the APB port: 0x0 capacity, 0x4 unique, 0x8 sorted,
// 0xC invert. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_ring_queue_core
  import orq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] push_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      out_value,
  output logic [4:0]       entry_count,
  output logic             is_empty,
  output logic             is_full,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] REG_CAP    = 2'd0;
  localparam logic [1:0] REG_UNIQUE = 2'd1;
  localparam logic [1:0] REG_SORTED = 2'd2;
  localparam logic [1:0] REG_INVERT = 2'd3;

  logic [4:0] active_capacity;
  logic       unique_enable;
  logic       sorted_enable;
  logic       invert_enable;
  logic       wr_en;
  logic       idle;
  ctl_t       ctl;
  sts_t       sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_capacity <= 5'd16;
      unique_enable   <= 1'b0;
      sorted_enable   <= 1'b0;
      invert_enable   <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CAP:    active_capacity <= pwdata[4:0];
        REG_UNIQUE: unique_enable   <= pwdata[0];
        REG_SORTED: sorted_enable   <= pwdata[0];
        REG_INVERT: invert_enable   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CAP:    prdata = {27'd0, active_capacity};
      REG_UNIQUE: prdata = {31'd0, unique_enable};
      REG_SORTED: prdata = {31'd0, sorted_enable};
      REG_INVERT: prdata = {31'd0, invert_enable};
      default:    prdata = '0;
    endcase
  end

  assign in_stall = !idle;

  orq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .unique_en (unique_enable),
    .sorted_en (sorted_enable),
    .sts       (sts),
    .ctl       (ctl),
    .idle      (idle)
  );

  orq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cmd         (cmd),
    .push_value  (push_value),
    .cap         (active_capacity),
    .invert_en   (invert_enable),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_value   (out_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

endmodule

`default_nettype wire
